### design/excitable_mesh_cell_update_top_macros.svh
// Assertion macros for the excitable mesh cell update block
`ifndef EXCITABLE_MESH_CELL_UPDATE_TOP_MACROS_SVH
`define EXCITABLE_MESH_CELL_UPDATE_TOP_MACROS_SVH
`ifndef SYNTH
`define EMCU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define EMCU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define EMCU_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define EMCU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/emcu_pkg.sv
// Types, codes, constants and helpers of the excitable mesh cell update block
`default_nettype none
package emcu_pkg;
	localparam int CELLS_DEF         = 4096;
	localparam int MAX_NEIGHBORS_DEF = 16;
	localparam int FRAC_BITS_DEF     = 12;

	localparam logic [15:0] TIME_STEP_RESET = 16'd655;
	localparam int          COUPLING_SHIFT  = 3;
	localparam int          DT_SHIFT        = 16;
	localparam logic [31:0] RECIP3          = 32'hAAAA_AAAB;
	localparam int          RECIP3_SHIFT    = 33;

	typedef enum logic [1:0] {
		OP_LOAD_CELL     = 2'd0,
		OP_LOAD_NEIGHBOR = 2'd1,
		OP_UPDATE        = 2'd2,
		OP_READ          = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_OWN,
		ST_WALK,
		ST_CALC,
		ST_COMMIT,
		ST_OUT
	} state_t;

	typedef enum logic {
		KIND_READ = 1'b0,
		KIND_DONE = 1'b1
	} kind_t;

	typedef struct packed {
		logic uv;
		logic par;
		logic nb;
		logic nx;
		logic pl;
	} store_we_t;

	typedef struct packed {
		logic               done;
		logic signed [15:0] u_next;
		logic signed [15:0] v_next;
	} calc_res_t;

	function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
		logic signed [15:0] r;
		if (x > 64'sd32767)
			r = 16'sh7FFF;
		else if (x < -64'sd32768)
			r = 16'sh8000;
		else
			r = x[15:0];
		return r;
	endfunction
endpackage
`default_nettype wire

### design/emcu_store.sv
// Cell, neighbor, shadow and pending-list memories
`default_nettype none
module emcu_store #(
	parameter int CELLS         = emcu_pkg::CELLS_DEF,
	parameter int MAX_NEIGHBORS = emcu_pkg::MAX_NEIGHBORS_DEF,
	parameter int AW            = $clog2(CELLS),
	parameter int TW            = $clog2(CELLS * MAX_NEIGHBORS),
	parameter int CW            = $clog2(MAX_NEIGHBORS + 1)
) (
	input  logic                   clk,
	input  emcu_pkg::store_we_t    we,
	input  logic [AW-1:0]          uv_waddr,
	input  logic signed [15:0]     u_wdata,
	input  logic signed [15:0]     v_wdata,
	input  logic [32+CW-1:0]       par_wdata,
	input  logic [AW-1:0]          cell_raddr,
	output logic signed [15:0]     u_rdata,
	output logic signed [15:0]     v_rdata,
	output logic [32+CW-1:0]       par_rdata,
	input  logic [TW-1:0]          nb_waddr,
	input  logic [11:0]            nb_wdata,
	input  logic [TW-1:0]          nb_raddr,
	output logic [11:0]            nb_rdata,
	input  logic [AW-1:0]          nx_waddr,
	input  logic [31:0]            nx_wdata,
	input  logic [AW-1:0]          nx_raddr,
	output logic [31:0]            nx_rdata,
	input  logic [AW-1:0]          pl_waddr,
	input  logic [AW-1:0]          pl_wdata,
	input  logic [AW-1:0]          pl_raddr,
	output logic [AW-1:0]          pl_rdata
);
	logic [15:0]      pot_mem [CELLS];
	logic [15:0]      rec_mem [CELLS];
	logic [32+CW-1:0] par_mem [CELLS];
	logic [11:0]      nb_mem  [CELLS * MAX_NEIGHBORS];
	logic [31:0]      nx_mem  [CELLS];
	logic [AW-1:0]    pl_mem  [CELLS];

	always_ff @(posedge clk) begin
		if (we.uv) begin
			pot_mem[uv_waddr] <= u_wdata;
			rec_mem[uv_waddr] <= v_wdata;
		end
		if (we.par)
			par_mem[uv_waddr] <= par_wdata;
		u_rdata   <= signed'(pot_mem[cell_raddr]);
		v_rdata   <= signed'(rec_mem[cell_raddr]);
		par_rdata <= par_mem[cell_raddr];
	end

	always_ff @(posedge clk) begin
		if (we.nb)
			nb_mem[nb_waddr] <= nb_wdata;
		nb_rdata <= nb_mem[nb_raddr];
	end

	always_ff @(posedge clk) begin
		if (we.nx)
			nx_mem[nx_waddr] <= nx_wdata;
		nx_rdata <= nx_mem[nx_raddr];
	end

	always_ff @(posedge clk) begin
		if (we.pl)
			pl_mem[pl_waddr] <= pl_wdata;
		pl_rdata <= pl_mem[pl_raddr];
	end
endmodule
`default_nettype wire

### design/emcu_calc.sv
// Five-stage arithmetic pipeline for the next potential and recovery of one cell
`default_nettype none
module emcu_calc #(
	parameter int FRAC_BITS = emcu_pkg::FRAC_BITS_DEF,
	parameter int SW        = 22
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [15:0]   u,
	input  logic signed [15:0]   v,
	input  logic signed [15:0]   a,
	input  logic signed [15:0]   e,
	input  logic signed [SW-1:0] sum,
	input  logic [15:0]          dt,
	output emcu_pkg::calc_res_t  res
);
	logic signed [16:0] dts;
	logic signed [16:0] uma;
	logic signed [SW-1:0] cpl;
	logic signed [31:0] y;
	logic               neg;
	logic [31:0]        m;
	logic [63:0]        qprod;
	logic signed [31:0] cube;
	logic signed [56:0] dprod;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [31:0] uu_s1;
	logic signed [32:0] ue_s1;
	logic signed [47:0] u3_s2;
	logic signed [49:0] uev_s2;
	logic [31:0]        q_s3;
	logic               neg_s3;
	logic signed [15:0] vn_s3;
	logic signed [39:0] du_s4;
	logic signed [15:0] un_s5;

	assign dts   = signed'({1'b0, dt});
	assign uma   = 17'(u) - 17'(a);
	assign cpl   = sum >>> emcu_pkg::COUPLING_SHIFT;
	assign y     = 32'(u3_s2 >>> (2 * FRAC_BITS));
	assign neg   = y[31];
	assign m     = neg ? 32'(32'sd2 - y) : 32'(y);
	assign qprod = {32'd0, m} * {32'd0, emcu_pkg::RECIP3};
	assign cube  = neg_s3 ? -signed'(q_s3) : signed'(q_s3);
	assign dprod = du_s4 * dts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		uu_s1  <= u * u;
		ue_s1  <= uma * e;
		u3_s2  <= uu_s1 * u;
		uev_s2 <= ue_s1 * dts;
		q_s3   <= 32'(qprod >> emcu_pkg::RECIP3_SHIFT);
		neg_s3 <= neg;
		vn_s3  <= emcu_pkg::sat16(64'(v) + 64'(uev_s2 >>> (FRAC_BITS + emcu_pkg::DT_SHIFT)));
		du_s4  <= 40'(u) - 40'(cube) - 40'(v) + 40'(cpl);
		un_s5  <= emcu_pkg::sat16(64'(u) + 64'(dprod >>> emcu_pkg::DT_SHIFT));
	end

	assign res.done   = vld_s5;
	assign res.u_next = un_s5;
	assign res.v_next = vn_s3;
endmodule
`default_nettype wire

### design/excitable_mesh_cell_update_top.sv
// Top level of the excitable mesh cell update block: sequencer, config and result register
//
//  channel | signals                          | beat
//  in      | in_valid/in_ready + item fields  | one item per beat
//  out     | out_valid/out_ready + results    | one result per beat
//  cfg     | APB psel/penable/pwrite/paddr    | time_step at address 0
//
// Loads write memory straight from idle. A read registers the cell's values, then the result
// register. An update reads the cell's own state, walks its neighbors with one neighbor
// table and potential read per cycle, then runs the five-stage arithmetic pipeline. A batch
// commit copies queued cells' shadow values back via the pending-list read port, then loads
// the result register. Reset clears control state only; memories hold garbage until
// written. A result waiting on out_ready stalls the next result-producing item.
`default_nettype none
`include "excitable_mesh_cell_update_top_macros.svh"
module excitable_mesh_cell_update_top #(
	parameter int CELLS         = emcu_pkg::CELLS_DEF,
	parameter int MAX_NEIGHBORS = emcu_pkg::MAX_NEIGHBORS_DEF,
	parameter int FRAC_BITS     = emcu_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [11:0]        cell_index,
	input  logic [3:0]         slot,
	input  logic [11:0]        neighbor_index,
	input  logic signed [15:0] potential_in,
	input  logic signed [15:0] recovery_in,
	input  logic signed [15:0] threshold_in,
	input  logic signed [15:0] rate_in,
	input  logic [4:0]         neighbor_total,
	input  logic               last_of_batch,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               result_kind,
	output logic [11:0]        cell_out,
	output logic signed [15:0] potential_out,
	output logic signed [15:0] recovery_out
);
	localparam int AW = $clog2(CELLS);
	localparam int TW = $clog2(CELLS * MAX_NEIGHBORS);
	localparam int CW = $clog2(MAX_NEIGHBORS + 1);
	localparam int XW = (AW > 12) ? AW : 12;
	localparam int SW = 18 + $clog2(MAX_NEIGHBORS + 1);
	localparam logic [AW:0] PEND_MAX = (AW + 1)'(CELLS);

	emcu_pkg::state_t    state_q, state_d;
	emcu_pkg::store_we_t we;
	emcu_pkg::calc_res_t cres;
	emcu_pkg::op_t       op;

	logic [15:0]        time_step_q;
	logic [XW-1:0]      cidx_x, nbx_x;
	logic [AW-1:0]      cidx_a, nbx_a;
	logic               inr, slot_ok, nb_ok;
	logic [CW-1:0]      cnt_sat;

	logic [AW-1:0]      cell_raddr, uv_waddr, pl_rdata;
	logic signed [15:0] u_rdata, v_rdata, u_wdata, v_wdata;
	logic [32+CW-1:0]   par_rdata;
	logic [TW-1:0]      nb_waddr, nb_raddr;
	logic [11:0]        nb_rdata;
	logic [31:0]        nx_rdata;

	logic               calc_start, walk_issue, cm_issue, out_load;

	logic [11:0]        c_q;
	logic [AW-1:0]      ca_q;
	logic [TW-1:0]      cbase_q;
	logic               last_q, inr_q;
	logic signed [15:0] u_q, v_q, a_q, e_q;
	logic [CW-1:0]      n_q, nb_i_q;
	logic               walk_s1, walk_s2;
	logic signed [SW-1:0] sum_q;
	logic [AW:0]        pend_cnt_q, cm_i_q;
	logic               cm_s1, cm_s2;
	logic [AW-1:0]      cm_p_s2;
	logic               res_kind_q;
	logic signed [15:0] res_u_q, res_v_q;
	logic               out_valid_q;
	logic               out_kind_q;
	logic [11:0]        out_cell_q;
	logic signed [15:0] out_u_q, out_v_q;

	assign op      = emcu_pkg::op_t'(operation);
	assign cidx_x  = XW'(cell_index);
	assign cidx_a  = cidx_x[AW-1:0];
	assign inr     = 32'(cell_index) < CELLS;
	assign slot_ok = 32'(slot) < MAX_NEIGHBORS;
	assign nbx_x   = XW'(nb_rdata);
	assign nbx_a   = nbx_x[AW-1:0];
	assign nb_ok   = 32'(nb_rdata) < CELLS;
	assign cnt_sat = (32'(neighbor_total) > MAX_NEIGHBORS) ? CW'(MAX_NEIGHBORS)
		: CW'(neighbor_total);
	assign nb_waddr = TW'(cidx_a) * TW'(MAX_NEIGHBORS) + TW'(slot);
	assign nb_raddr = cbase_q + TW'(nb_i_q);

	// config port
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {16'd0, time_step_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			time_step_q <= emcu_pkg::TIME_STEP_RESET;
		else if (psel && penable && pwrite && pready && !paddr[2])
			time_step_q <= pwdata[15:0];
	end

	emcu_store #(
		.CELLS(CELLS), .MAX_NEIGHBORS(MAX_NEIGHBORS), .AW(AW), .TW(TW), .CW(CW)
	) u_store (
		.clk(clk),
		.we(we),
		.uv_waddr(uv_waddr),
		.u_wdata(u_wdata),
		.v_wdata(v_wdata),
		.par_wdata({threshold_in, rate_in, cnt_sat}),
		.cell_raddr(cell_raddr),
		.u_rdata(u_rdata),
		.v_rdata(v_rdata),
		.par_rdata(par_rdata),
		.nb_waddr(nb_waddr),
		.nb_wdata(neighbor_index),
		.nb_raddr(nb_raddr),
		.nb_rdata(nb_rdata),
		.nx_waddr(ca_q),
		.nx_wdata({cres.u_next, cres.v_next}),
		.nx_raddr(pl_rdata),
		.nx_rdata(nx_rdata),
		.pl_waddr(pend_cnt_q[AW-1:0]),
		.pl_wdata(ca_q),
		.pl_raddr(cm_i_q[AW-1:0]),
		.pl_rdata(pl_rdata)
	);

	emcu_calc #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_calc (
		.clk(clk),
		.arst_n(arst_n),
		.start(calc_start),
		.u(u_q),
		.v(v_q),
		.a(a_q),
		.e(e_q),
		.sum(sum_q),
		.dt(time_step_q),
		.res(cres)
	);

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		we         = '0;
		cell_raddr = nbx_a;
		uv_waddr   = cidx_a;
		u_wdata    = potential_in;
		v_wdata    = recovery_in;
		calc_start = 1'b0;
		walk_issue = 1'b0;
		cm_issue   = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			emcu_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cell_raddr = cidx_a;
				if (in_valid) begin
					unique case (op)
						emcu_pkg::OP_LOAD_CELL: begin
							we.uv  = inr;
							we.par = inr;
						end
						emcu_pkg::OP_LOAD_NEIGHBOR: we.nb = inr && slot_ok;
						emcu_pkg::OP_UPDATE: begin
							if (inr && pend_cnt_q < PEND_MAX)
								state_d = emcu_pkg::ST_OWN;
							else if (last_of_batch)
								state_d = emcu_pkg::ST_COMMIT;
						end
						emcu_pkg::OP_READ: state_d = emcu_pkg::ST_READ;
						default: state_d = emcu_pkg::ST_IDLE;
					endcase
				end
			end
			emcu_pkg::ST_READ: state_d = emcu_pkg::ST_OUT;
			emcu_pkg::ST_OWN: state_d = emcu_pkg::ST_WALK;
			emcu_pkg::ST_WALK: begin
				walk_issue = nb_i_q < n_q;
				if (!walk_issue && !walk_s1 && !walk_s2) begin
					calc_start = 1'b1;
					state_d    = emcu_pkg::ST_CALC;
				end
			end
			emcu_pkg::ST_CALC: begin
				if (cres.done) begin
					we.nx   = 1'b1;
					we.pl   = 1'b1;
					state_d = last_q ? emcu_pkg::ST_COMMIT : emcu_pkg::ST_IDLE;
				end
			end
			emcu_pkg::ST_COMMIT: begin
				cm_issue = cm_i_q < pend_cnt_q;
				we.uv    = cm_s2;
				uv_waddr = cm_p_s2;
				u_wdata  = signed'(nx_rdata[31:16]);
				v_wdata  = signed'(nx_rdata[15:0]);
				if (!cm_issue && !cm_s1 && !cm_s2)
					state_d = emcu_pkg::ST_OUT;
			end
			emcu_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = emcu_pkg::ST_IDLE;
				end
			end
			default: state_d = emcu_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= emcu_pkg::ST_IDLE;
			pend_cnt_q  <= '0;
			nb_i_q      <= '0;
			walk_s1     <= 1'b0;
			walk_s2     <= 1'b0;
			cm_i_q      <= '0;
			cm_s1       <= 1'b0;
			cm_s2       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == emcu_pkg::ST_WALK) begin
				if (walk_issue)
					nb_i_q <= nb_i_q + 1'b1;
				walk_s1 <= walk_issue;
				walk_s2 <= walk_s1 && nb_ok;
			end else begin
				nb_i_q  <= '0;
				walk_s1 <= 1'b0;
				walk_s2 <= 1'b0;
			end
			if (state_q == emcu_pkg::ST_COMMIT) begin
				if (cm_issue)
					cm_i_q <= cm_i_q + 1'b1;
				cm_s1 <= cm_issue;
				cm_s2 <= cm_s1;
			end else begin
				cm_i_q <= '0;
				cm_s1  <= 1'b0;
				cm_s2  <= 1'b0;
			end
			if (we.pl)
				pend_cnt_q <= pend_cnt_q + 1'b1;
			else if (state_q == emcu_pkg::ST_COMMIT && state_d == emcu_pkg::ST_OUT)
				pend_cnt_q <= '0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == emcu_pkg::ST_IDLE && in_valid) begin
			c_q     <= cell_index;
			ca_q    <= cidx_a;
			cbase_q <= TW'(cidx_a) * TW'(MAX_NEIGHBORS);
			last_q  <= last_of_batch;
			inr_q   <= inr;
		end
		if (state_q == emcu_pkg::ST_READ) begin
			res_kind_q <= emcu_pkg::KIND_READ;
			res_u_q    <= inr_q ? u_rdata : 16'sd0;
			res_v_q    <= inr_q ? v_rdata : 16'sd0;
		end
		if (state_q == emcu_pkg::ST_OWN) begin
			u_q   <= u_rdata;
			v_q   <= v_rdata;
			a_q   <= signed'(par_rdata[32+CW-1:16+CW]);
			e_q   <= signed'(par_rdata[16+CW-1:CW]);
			n_q   <= par_rdata[CW-1:0];
			sum_q <= '0;
		end
		if (state_q == emcu_pkg::ST_WALK && walk_s2)
			sum_q <= sum_q + SW'(u_rdata) - SW'(u_q);
		cm_p_s2 <= pl_rdata;
		if (state_q == emcu_pkg::ST_COMMIT && state_d == emcu_pkg::ST_OUT) begin
			res_kind_q <= emcu_pkg::KIND_DONE;
			res_u_q    <= 16'sd0;
			res_v_q    <= 16'sd0;
		end
		if (out_load) begin
			out_kind_q <= res_kind_q;
			out_cell_q <= c_q;
			out_u_q    <= res_u_q;
			out_v_q    <= res_v_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = out_kind_q;
	assign cell_out      = out_cell_q;
	assign potential_out = out_u_q;
	assign recovery_out  = out_v_q;

	`EMCU_ASSERT_SAME(a_pend_bound, clk, arst_n, 1'b1, pend_cnt_q <= PEND_MAX)
	`EMCU_ASSERT_SAME(a_walk_bound, clk, arst_n, state_q == emcu_pkg::ST_WALK, nb_i_q <= n_q)
	`EMCU_ASSERT_NEXT(a_calc_exit, clk, arst_n, state_q == emcu_pkg::ST_CALC && cres.done, state_q == emcu_pkg::ST_COMMIT || state_q == emcu_pkg::ST_IDLE)
	`EMCU_ASSERT_NEXT(a_commit_done, clk, arst_n, state_q == emcu_pkg::ST_COMMIT && state_d == emcu_pkg::ST_OUT, res_kind_q == emcu_pkg::KIND_DONE && pend_cnt_q == '0)
endmodule
`default_nettype wire
